FILE: sv/mwd_pkg.sv
// shared types, constants and helpers for the masked window dilation block
package mwd_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int WINDOW_SIZE_DEF = 5;
  localparam int HEIGHT_LIMIT    = 1024;
  localparam int ROW_W           = $clog2(HEIGHT_LIMIT);
  localparam int CFG_W           = 11;
  localparam int CFG_IDX_W       = 2;
  localparam int CHAN_W          = 8;
  localparam int NUM_CH          = 3;

  localparam logic [CFG_W-1:0]  WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0]  HEIGHT_RESET = CFG_W'(480);
  localparam logic [CHAN_W-1:0] MATCH_RESET  = CHAN_W'(32);

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MATCH  = CFG_IDX_W'(2);

  typedef struct packed {
    logic [CHAN_W-1:0] pix_red;
    logic [CHAN_W-1:0] pix_green;
    logic [CHAN_W-1:0] pix_blue;
    logic [CHAN_W-1:0] mask_red;
    logic [CHAN_W-1:0] mask_green;
    logic [CHAN_W-1:0] mask_blue;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              frame_last;
  } out_word_t;

  // index 0 red, 1 green, 2 blue
  typedef logic [NUM_CH-1:0][CHAN_W-1:0] rgb_t;

  function automatic rgb_t pix_rgb(input in_word_t w);
    rgb_t v;
    v[0] = w.pix_red;
    v[1] = w.pix_green;
    v[2] = w.pix_blue;
    return v;
  endfunction

  function automatic rgb_t mask_rgb(input in_word_t w);
    rgb_t v;
    v[0] = w.mask_red;
    v[1] = w.mask_green;
    v[2] = w.mask_blue;
    return v;
  endfunction

endpackage

FILE: sv/mwd_linestore.sv
// line store: one word per column holding the previous rows of that column
module mwd_linestore import mwd_pkg::*; #(
  parameter int DEPTH = MAX_WIDTH_DEF,
  parameter int ROWS  = WINDOW_SIZE_DEF - 1
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output in_word_t [ROWS-1:0]      rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  in_word_t [ROWS-1:0]      wr_data
);

  in_word_t [ROWS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/mwd_cell.sv
// window column cell: holds one column of the window and its masked column maximum
module mwd_cell import mwd_pkg::*; #(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift,
  input  in_word_t [WINDOW_SIZE-1:0] col_in,
  input  logic [CHAN_W-1:0]          match_value,
  output in_word_t [WINDOW_SIZE-1:0] col_out,
  output rgb_t                       col_max
);

  in_word_t [WINDOW_SIZE-1:0] col_regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_regs <= '0;
    end else if (shift) begin
      col_regs <= col_in;
    end
  end

  assign col_out = col_regs;

  always_comb begin
    rgb_t pix;
    rgb_t msk;
    col_max = '0;
    for (int r = 0; r < WINDOW_SIZE; r++) begin
      pix = pix_rgb(col_regs[r]);
      msk = mask_rgb(col_regs[r]);
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (msk[ch] == match_value && pix[ch] > col_max[ch]) begin
          col_max[ch] = pix[ch];
        end
      end
    end
  end

endmodule

FILE: sv/masked_window_dilation.sv
// top level: masked greyscale dilation over a square window of an rgb pixel stream
//
// One pixel word (image pixel plus control pixel) is taken per clock in raster order;
// the sustained rate is one word per cycle while in_stall is low, set by the line
// store, which is read once (registered) and written once per word through separate
// ports. A result word passes line store read, window shift in the chain of column
// cells with each cell forming its masked column maximum, the column maxima register,
// then the maximum across columns with the fall-back to the centre pixel. Only
// interior centres give a result, (W-4)x(H-4) per frame for a 5x5 window, and
// frame_last marks the last of them. in_stall rises only while the input stage
// holds a word, every later stage holds a result and the output is stalled.
// Writing image_width or image_height restarts the frame position; match_value takes
// effect at once.
module masked_window_dilation import mwd_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EW    = $clog2(MAX_WIDTH + 1);
  localparam int CW    = (EW > CFG_W) ? EW : CFG_W;
  localparam int HALF  = WINDOW_SIZE / 2;
  localparam int ROWS  = WINDOW_SIZE - 1;

  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  image_height;
  logic [CHAN_W-1:0] match_value;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;

  logic [CW-1:0]    w_ext;
  logic [CW-1:0]    eff_w;
  logic [CW-1:0]    w_last;
  logic [CFG_W-1:0] eff_h;
  logic [CFG_W-1:0] h_last;
  logic             at_col_end;
  logic             at_row_end;
  logic             interior;
  logic             accept;

  // stage a: word registered, line store read in flight
  logic             a_valid;
  in_word_t         a_word;
  logic [COL_W-1:0] a_col;
  logic             a_emit;
  logic             a_last;
  logic             a_move;

  // stage b: window holds this word's neighbourhood
  logic b_valid;
  logic b_emit;
  logic b_last;
  logic b_ready;
  logic b_go;

  // stage c: column maxima registered
  logic                   c_valid;
  rgb_t [WINDOW_SIZE-1:0] c_max;
  rgb_t                   c_centre;
  logic                   c_last;
  logic                   c_ready;
  logic                   c_load;
  logic                   out_ok;

  in_word_t [ROWS-1:0]        rd_rows;
  in_word_t [ROWS-1:0]        wr_rows;
  in_word_t [WINDOW_SIZE-1:0] new_col;
  in_word_t [WINDOW_SIZE-1:0] cell_col  [WINDOW_SIZE];
  rgb_t                       cell_max  [WINDOW_SIZE];
  out_word_t                  out_next;

  // effective geometry, saturated to the legal range
  assign w_ext = CW'(image_width);
  assign eff_w = (w_ext < CW'(WINDOW_SIZE)) ? CW'(WINDOW_SIZE) :
                 (w_ext > CW'(MAX_WIDTH))   ? CW'(MAX_WIDTH)   : w_ext;
  assign w_last = eff_w - CW'(1);
  assign eff_h = (image_height < CFG_W'(WINDOW_SIZE))  ? CFG_W'(WINDOW_SIZE) :
                 (image_height > CFG_W'(HEIGHT_LIMIT)) ? CFG_W'(HEIGHT_LIMIT) : image_height;
  assign h_last = eff_h - CFG_W'(1);

  assign at_col_end = (CW'(col) == w_last);
  assign at_row_end = (CFG_W'(row) == h_last);
  assign interior   = (CW'(col) >= CW'(WINDOW_SIZE - 1)) &&
                      (CFG_W'(row) >= CFG_W'(WINDOW_SIZE - 1));

  always_comb begin
    col_next = col + COL_W'(1);
    row_next = row;
    if (at_col_end) begin
      col_next = '0;
      row_next = at_row_end ? '0 : row + ROW_W'(1);
    end
  end

  // handshake chain from the output back to the input
  assign out_ok   = ~out_valid | ~out_stall;
  assign c_ready  = ~c_valid | out_ok;
  assign b_ready  = ~b_valid | ~b_emit | c_ready;
  assign b_go     = b_valid & (~b_emit | c_ready);
  assign c_load   = b_valid & b_emit & c_ready;
  assign a_move   = a_valid & b_ready;
  assign in_stall = a_valid & ~b_ready;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      match_value  <= MATCH_RESET;
      col          <= '0;
      row          <= '0;
    end else begin
      if (accept) begin
        col <= col_next;
        row <= row_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH: begin
            image_width <= cfg_data;
            col         <= '0;
            row         <= '0;
          end
          REG_HEIGHT: begin
            image_height <= cfg_data;
            col          <= '0;
            row          <= '0;
          end
          REG_MATCH: begin
            match_value <= cfg_data[CHAN_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // control valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end
      if (a_move) begin
        b_valid <= 1'b1;
      end else if (b_go) begin
        b_valid <= 1'b0;
      end
      if (c_load) begin
        c_valid <= 1'b1;
      end else if (c_valid && out_ok) begin
        c_valid <= 1'b0;
      end
      if (c_valid && out_ok) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      a_word <= in_word;
      a_col  <= col;
      a_emit <= interior;
      a_last <= at_col_end & at_row_end;
    end
    if (a_move) begin
      b_emit <= a_emit;
      b_last <= a_last;
    end
    if (c_load) begin
      for (int c = 0; c < WINDOW_SIZE; c++) begin
        c_max[c] <= cell_max[c];
      end
      c_centre <= pix_rgb(cell_col[HALF][HALF]);
      c_last   <= b_last;
    end
    if (c_valid && out_ok) begin
      out_word <= out_next;
    end
  end

  mwd_linestore #(
    .DEPTH (MAX_WIDTH),
    .ROWS  (ROWS)
  ) u_linestore (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (rd_rows),
    .wr_en   (a_move),
    .wr_addr (a_col),
    .wr_data (wr_rows)
  );

  // column pushed up through the store, new word enters at the bottom
  always_comb begin
    for (int r = 0; r < ROWS - 1; r++) begin
      wr_rows[r] = rd_rows[r + 1];
    end
    wr_rows[ROWS-1] = a_word;
    for (int r = 0; r < ROWS; r++) begin
      new_col[r] = rd_rows[r];
    end
    new_col[WINDOW_SIZE-1] = a_word;
  end

  for (genvar c = 0; c < WINDOW_SIZE; c++) begin : g_cell
    in_word_t [WINDOW_SIZE-1:0] feed;
    if (c == WINDOW_SIZE - 1) begin : g_edge
      assign feed = new_col;
    end else begin : g_inner
      assign feed = cell_col[c + 1];
    end
    mwd_cell #(
      .WINDOW_SIZE (WINDOW_SIZE)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .shift       (a_move),
      .col_in      (feed),
      .match_value (match_value),
      .col_out     (cell_col[c]),
      .col_max     (cell_max[c])
    );
  end

  // maximum across columns, centre pixel where that maximum is zero
  always_comb begin
    rgb_t best;
    best = '0;
    for (int c = 0; c < WINDOW_SIZE; c++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (c_max[c][ch] > best[ch]) begin
          best[ch] = c_max[c][ch];
        end
      end
    end
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (best[ch] == '0) begin
        best[ch] = c_centre[ch];
      end
    end
    out_next.out_red    = best[0];
    out_next.out_green  = best[1];
    out_next.out_blue   = best[2];
    out_next.frame_last = c_last;
  end

endmodule

FILE: sv/mwd_checker.sv
// port-level checks for the masked window dilation block, bound to the top level
module mwd_checker import mwd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // a stalled result word stays and holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present right after reset");

  // input back-pressure only when a result is waiting downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // a stalled pixel word stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("pixel word changed while stalled");

endmodule

bind masked_window_dilation mwd_checker u_mwd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
